### rtl/alfl_pkg.sv
// Shared constants, command codes and controller/datapath bundles for the
// linked-list node pool. No dependencies.
package alfl_pkg;

	localparam int NODE_COUNT = 16;
	localparam int KEY_BITS   = 32;
	localparam int NODE_W     = 5;
	localparam int KEY_W      = 32;
	localparam int CMD_W      = 2;
	localparam int IDX_W      = $clog2(NODE_COUNT);

	localparam logic [NODE_W-1:0] NULL_NODE = NODE_W'(NODE_COUNT);

	localparam logic [CMD_W-1:0] CMD_CONS   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_UNLINK = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FREE   = 2'd2;

	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_NO_SPACE = 1'b1;

	typedef struct packed {
		logic capture;
		logic rd_cons;
		logic rd_unlink;
		logic do_free;
		logic wr_cons;
		logic wr_tail;
		logic wr_unlink;
		logic load_result;
	} dp_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             head_null;
		logic             node_null;
	} dp_status_t;

	function automatic logic is_node(input logic [NODE_W-1:0] v);
		return v < NULL_NODE;
	endfunction

endpackage

### rtl/alfl_req_if.sv
// Request channel: command, node and key with a valid/ready transfer.
// Depends on alfl_pkg.
interface alfl_req_if;
	import alfl_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         command;
	logic [NODE_W-1:0]        node;
	logic signed [KEY_W-1:0]  key_value;

	modport source(output valid, command, node, key_value, input ready);
	modport sink(input valid, command, node, key_value, output ready);
endinterface

### rtl/alfl_rsp_if.sv
// Result channel: allocated node and status with a valid/ready transfer.
// Depends on alfl_pkg.
interface alfl_rsp_if;
	import alfl_pkg::*;
	logic              valid;
	logic              ready;
	logic [NODE_W-1:0] new_node;
	logic              status;

	modport source(output valid, new_node, status, input ready);
	modport sink(input valid, new_node, status, output ready);
endinterface

### rtl/alfl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module alfl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### rtl/alfl_ctrl.sv
// Sequencing state machine for the node pool: steps each command through
// its read and write passes. Depends on alfl_pkg.
module alfl_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  alfl_pkg::dp_status_t stat,
	output alfl_pkg::dp_cmd_t    cmd
);
	import alfl_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_WR1  = 3'd2;
	localparam logic [2:0] S_WR2  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_RD;
				end
			end
			S_RD: begin
				case (stat.cmd)
					CMD_CONS: begin
						cmd.rd_cons = 1'b1;
						state_d     = stat.head_null ? S_DONE : S_WR1;
					end
					CMD_UNLINK: begin
						cmd.rd_unlink = !stat.node_null;
						state_d       = stat.node_null ? S_DONE : S_WR1;
					end
					CMD_FREE: begin
						cmd.do_free = !stat.node_null;
						state_d     = S_DONE;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_WR1: begin
				if (stat.cmd == CMD_CONS) begin
					cmd.wr_cons = 1'b1;
					state_d     = S_WR2;
				end else begin
					cmd.wr_unlink = 1'b1;
					state_d       = S_DONE;
				end
			end
			S_WR2: begin
				// The tail link is written last so a self-tail links to itself.
				cmd.wr_tail = 1'b1;
				state_d     = S_DONE;
			end
			S_DONE: begin
				if (slot_free) begin
					cmd.load_result = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_accept_to_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_RD))
		else $error("accepted request did not enter the read pass");
	a_load_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_result |-> slot_free)
		else $error("result loaded over an untaken result");
	a_empty_pool: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD && stat.cmd == CMD_CONS && stat.head_null)
		|=> (state_q == S_DONE))
		else $error("cons on empty pool did not go straight to result");
`endif
endmodule

### rtl/alfl_dp.sv
// Datapath of the node pool: key, next and prev stores, free-list head,
// command capture and result register. Depends on alfl_pkg and alfl_ram.
module alfl_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  alfl_pkg::dp_cmd_t             cmd,
	output alfl_pkg::dp_status_t          stat,
	input  logic [alfl_pkg::CMD_W-1:0]    in_command,
	input  logic [alfl_pkg::NODE_W-1:0]   in_node,
	input  logic signed [alfl_pkg::KEY_W-1:0] in_key,
	output logic [alfl_pkg::NODE_W-1:0]   new_node,
	output logic                          status
);
	import alfl_pkg::*;

	logic [CMD_W-1:0]          cmd_q;
	logic [NODE_W-1:0]         node_q;
	logic signed [KEY_BITS-1:0] key_q;
	logic [NODE_W-1:0]         free_head_q;
	logic [NODE_W-1:0]         x_q;
	logic [NODE_COUNT-1:0]     next_vld_q;
	logic [IDX_W-1:0]          next_raddr_q;
	logic                      next_rvld_q;
	logic [NODE_W-1:0]         new_node_q;
	logic                      status_q;

	logic                      next_we, prev_we;
	logic [IDX_W-1:0]          next_waddr, prev_waddr, next_raddr;
	logic [NODE_W-1:0]         next_wdata, prev_wdata;
	logic [NODE_W-1:0]         next_ram, prev_rd, next_rd;
	logic [IDX_W-1:0]          node_idx, x_idx;
	logic                      cons_ok;

	assign node_idx = node_q[IDX_W-1:0];
	assign x_idx    = x_q[IDX_W-1:0];

	// An entry never written since reset still holds its reset link, i+1.
	assign next_rd = next_rvld_q ? next_ram : (NODE_W'(next_raddr_q) + NODE_W'(1));
	assign next_raddr = cmd.rd_cons ? free_head_q[IDX_W-1:0] : node_idx;

	always_comb begin
		next_we    = 1'b0;
		next_waddr = x_idx;
		next_wdata = NULL_NODE;
		prev_we    = 1'b0;
		prev_waddr = x_idx;
		prev_wdata = is_node(node_q) ? node_q : NULL_NODE;
		if (cmd.do_free) begin
			next_we    = 1'b1;
			next_waddr = node_idx;
			next_wdata = free_head_q;
		end
		if (cmd.wr_cons) begin
			next_we = 1'b1;
			prev_we = 1'b1;
		end
		if (cmd.wr_tail) begin
			next_we    = is_node(node_q);
			next_waddr = node_idx;
			next_wdata = x_q;
		end
		if (cmd.wr_unlink) begin
			next_we    = is_node(prev_rd);
			next_waddr = prev_rd[IDX_W-1:0];
			next_wdata = next_rd;
			prev_we    = is_node(next_rd);
			prev_waddr = next_rd[IDX_W-1:0];
			prev_wdata = prev_rd;
		end
	end

	alfl_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_next_ram (
		.clk  (clk),
		.we   (next_we),
		.waddr(next_waddr),
		.wdata(next_wdata),
		.raddr(next_raddr),
		.rdata(next_ram)
	);

	alfl_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_prev_ram (
		.clk  (clk),
		.we   (prev_we),
		.waddr(prev_waddr),
		.wdata(prev_wdata),
		.raddr(node_idx),
		.rdata(prev_rd)
	);

	alfl_ram #(.WIDTH(KEY_BITS), .DEPTH(NODE_COUNT)) u_key_ram (
		.clk  (clk),
		.we   (cmd.wr_cons),
		.waddr(x_idx),
		.wdata(key_q),
		.raddr(x_idx),
		.rdata()
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q  <= in_command;
			node_q <= in_node;
			key_q  <= KEY_BITS'(in_key);
		end
		if (cmd.rd_cons) begin
			x_q <= free_head_q;
		end
		if (cmd.rd_cons || cmd.rd_unlink) begin
			next_raddr_q <= next_raddr;
			next_rvld_q  <= next_vld_q[next_raddr];
		end
		if (cmd.load_result) begin
			new_node_q <= cons_ok ? x_q : NULL_NODE;
			status_q   <= (cmd_q == CMD_CONS && !cons_ok) ? STATUS_NO_SPACE : STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			next_vld_q  <= '0;
		end else begin
			if (next_we) begin
				next_vld_q[next_waddr] <= 1'b1;
			end
			if (cmd.do_free) begin
				free_head_q <= node_q;
			end else if (cmd.wr_cons) begin
				free_head_q <= next_rd;
			end
		end
	end

	assign cons_ok        = (cmd_q == CMD_CONS) && is_node(x_q);
	assign stat.cmd       = cmd_q;
	assign stat.head_null = !is_node(free_head_q);
	assign stat.node_null = !is_node(node_q);
	assign new_node       = new_node_q;
	assign status         = status_q;

`ifndef ASSERT_OFF
	a_free_head: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_free |=> (free_head_q == $past(node_q)))
		else $error("free did not push the node onto the free list");
	a_cons_node: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_cons || cmd.wr_tail) |-> is_node(x_q))
		else $error("cons writing with no allocated node");
	a_free_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_free |-> is_node(node_q))
		else $error("free issued for a null node");
`endif
endmodule

### rtl/array_linked_list_with_free_list.sv
// Top level of the doubly linked node pool with free list.
// Cons runs the read pass and two write passes, unlink the read pass and one write
// pass; free, a cons on an empty pool and null or unused commands the read pass only.
// All end in the result step, and one command is in flight at a time: no new request
// is taken until that step loads its result, which waits while a result is untaken.
// Reset (arst_n low) chains all nodes into the free list at once via per-entry
// valid bits on the next store; a request can be taken as soon as reset is released.
module array_linked_list_with_free_list (
	input logic       clk,
	input logic       arst_n,
	alfl_req_if.sink  request,
	alfl_rsp_if.source result
);
	import alfl_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t stat;

	alfl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (request.valid),
		.in_ready (request.ready),
		.out_valid(result.valid),
		.out_ready(result.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	alfl_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_command(request.command),
		.in_node   (request.node),
		.in_key    (request.key_value),
		.new_node  (result.new_node),
		.status    (result.status)
	);
endmodule
